>>> hw/rtl/sack_pkg.sv
// sack_pkg: shared constants and types for the SACK reassembly scoreboard.
// No dependencies.
package sack_pkg;
	localparam int unsigned MAX_BLOCKS_DEF = 16;
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned CNT_W = 5;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADVANCE,
		OP_MERGE
	} op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		op_t         op;
		logic [31:0] s;
		logic [31:0] e;
	} cell_cmd_t;
endpackage

>>> hw/rtl/sack_cell.sv
// sack_cell: one slot of the block chain; holds begin/end and a valid bit.
// Depends on sack_pkg.
module sack_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  sack_pkg::cell_cmd_t cmd,
	input  logic [31:0]         point,
	input  logic                ins_here,
	input  logic                left_ins,
	input  logic                close_up,
	input  logic                left_v,
	input  logic [31:0]         left_b,
	input  logic [31:0]         left_e,
	input  logic                right_v,
	input  logic [31:0]         right_b,
	input  logic [31:0]         right_e,
	output logic                v,
	output logic [31:0]         b,
	output logic [31:0]         e,
	output logic                ins_before,
	output logic                drop,
	output logic                touch
);
	logic        v_q;
	logic [31:0] b_q, e_q;

	assign v = v_q;
	assign b = b_q;
	assign e = e_q;
	// merge mode: this cell overlaps or touches the new range
	assign touch = v_q && (b_q <= cmd.e) && (e_q >= cmd.s);
	// lies wholly above the new range: the new entry sits at or before here
	assign ins_before = v_q && (b_q > cmd.e);
	// advance mode: swallowed by the cumulative point
	assign drop = v_q && (b_q <= point);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			b_q <= '0;
			e_q <= '0;
		end else if (step) begin
			case (cmd.op)
				sack_pkg::OP_ADVANCE: begin
					// whole chain shifts left while the head drops
					v_q <= right_v;
					b_q <= right_b;
					e_q <= right_e;
				end
				sack_pkg::OP_MERGE: begin
					if (ins_here) begin
						v_q <= 1'b1;
						b_q <= cmd.s;
						e_q <= cmd.e;
					end else if (left_ins) begin
						v_q <= left_v;
						b_q <= left_b;
						e_q <= left_e;
					end else if (close_up) begin
						v_q <= right_v;
						b_q <= right_b;
						e_q <= right_e;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

>>> hw/rtl/sack_reassembly_scoreboard.sv
// sack_reassembly_scoreboard: top level, controller plus chain of sack_cell.
// Depends on sack_pkg and sack_cell.
//
// channel | direction | signals
// in      | input     | in_valid, in_ready, seq_start, range_length
// out     | output    | out_valid, out_ready, cum_point, total_received,
//         |           |   block_count, overflow
//
// A word is taken in idle and then decided; an advance or merge pass then
// handles one absorbed or merged block per step, plus a final step (none
// when the range changes nothing or overflows); a sum pass reads one cell a
// cycle, then the result loads. Cell valid bits reset at once.
// A stalled result holds in the output register; the next word waits for it.
module sack_reassembly_scoreboard #(
	parameter int unsigned MAX_BLOCKS = sack_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] seq_start,
	input  logic [15:0] range_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] cum_point,
	output logic [31:0] total_received,
	output logic [4:0]  block_count,
	output logic        overflow
);
	localparam int unsigned N = MAX_BLOCKS;
	localparam int unsigned CW = $clog2(N + 1);
	localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_ADV, ST_MERGE, ST_SUM, ST_OUT
	} state_t;

	state_t              st_q;
	sack_pkg::cell_cmd_t cmd_q;
	logic [31:0]         point_q, total_q;
	logic [CW-1:0]       held_q;
	logic [IW-1:0]       sum_i_q;
	logic                ovf_q;
	logic [31:0]         out_cum_q, out_tot_q;
	logic [4:0]          out_cnt_q;
	logic                out_ovf_q, out_v_q;

	logic [N-1:0] cv, ins_b, drp, tch, ins_here, left_ins, close_up, first_tch, step_v;
	logic [31:0]  cb [N];
	logic [31:0]  ce [N];
	logic [N-1:0] lv, rv;
	logic [31:0]  lb [N];
	logic [31:0]  le [N];
	logic [31:0]  rb [N];
	logic [31:0]  re [N];
	logic         any_touch;
	logic [31:0]  uni_b, uni_e;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g + 1 < N) begin : g_r
				assign rv[g] = cv[g+1];
				assign rb[g] = cb[g+1];
				assign re[g] = ce[g+1];
			end else begin : g_last
				assign rv[g] = 1'b0;
				assign rb[g] = '0;
				assign re[g] = '0;
			end
			if (g > 0) begin : g_l
				assign lv[g] = cv[g-1];
				assign lb[g] = cb[g-1];
				assign le[g] = ce[g-1];
			end else begin : g_first
				assign lv[g] = 1'b0;
				assign lb[g] = '0;
				assign le[g] = '0;
			end
			sack_cell u_cell (
				.clk(clk), .arst_n(arst_n), .step(step_v[g]), .cmd(cmd_q),
				.point(point_q),
				.ins_here(ins_here[g]), .left_ins(left_ins[g]), .close_up(close_up[g]),
				.left_v(lv[g]), .left_b(lb[g]), .left_e(le[g]),
				.right_v(rv[g]), .right_b(rb[g]), .right_e(re[g]),
				.v(cv[g]), .b(cb[g]), .e(ce[g]),
				.ins_before(ins_b[g]), .drop(drp[g]), .touch(tch[g])
			);
		end
	endgenerate

	// merge: the first touching cell leaves and the rest close up; with no
	// touch the range goes in at the first free or higher cell
	always_comb begin
		logic p_sh, p_cd, cd;
		any_touch = |tch;
		p_sh = 1'b0;
		p_cd = 1'b0;
		uni_b = '0;
		uni_e = '0;
		for (int k = 0; k < N; k++) begin
			first_tch[k] = tch[k] && !p_sh;
			close_up[k]  = tch[k] || p_sh;
			p_sh = close_up[k];
			cd = !cv[k] || ins_b[k];
			ins_here[k] = !any_touch && cd && !p_cd;
			left_ins[k] = !any_touch && p_cd;
			p_cd = cd;
			if (first_tch[k]) begin
				uni_b = uni_b | cb[k];
				uni_e = uni_e | ce[k];
			end
			if (st_q == ST_ADV) step_v[k] = drp[0];
			else if (st_q == ST_MERGE) step_v[k] = 1'b1;
			else step_v[k] = 1'b0;
		end
	end

	logic [32:0] e33;
	assign e33 = {1'b0, seq_start} + 33'(range_length);
	assign in_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cmd_q     <= '0;
			point_q   <= '0;
			total_q   <= '0;
			held_q    <= '0;
			sum_i_q   <= '0;
			ovf_q     <= 1'b0;
			out_cum_q <= '0;
			out_tot_q <= '0;
			out_cnt_q <= '0;
			out_ovf_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q.s  <= seq_start;
						cmd_q.e  <= e33[32] ? 32'hFFFF_FFFF : e33[31:0];
						cmd_q.op <= sack_pkg::OP_NONE;
						ovf_q    <= 1'b0;
						st_q     <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (cmd_q.e > cmd_q.s && cmd_q.e > point_q) begin
						if (cmd_q.s <= point_q) begin
							point_q  <= cmd_q.e;
							cmd_q.op <= sack_pkg::OP_ADVANCE;
							st_q     <= ST_ADV;
						end else if (!any_touch && (held_q >= CW'(N))) begin
							ovf_q <= 1'b1;
							st_q  <= ST_SUM;
						end else begin
							cmd_q.op <= sack_pkg::OP_MERGE;
							st_q     <= ST_MERGE;
						end
					end else begin
						st_q <= ST_SUM;
					end
					total_q <= '0;
					sum_i_q <= '0;
				end
				ST_ADV: begin
					if (drp[0]) begin
						if (ce[0] > point_q) point_q <= ce[0];
						held_q <= held_q - CW'(1);
					end else begin
						cmd_q.op <= sack_pkg::OP_NONE;
						st_q     <= ST_SUM;
					end
				end
				ST_MERGE: begin
					if (any_touch) begin
						held_q <= held_q - CW'(1);
						if (uni_b < cmd_q.s) cmd_q.s <= uni_b;
						if (uni_e > cmd_q.e) cmd_q.e <= uni_e;
					end else begin
						held_q   <= held_q + CW'(1);
						cmd_q.op <= sack_pkg::OP_NONE;
						st_q     <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (cv[sum_i_q]) total_q <= total_q + (ce[sum_i_q] - cb[sum_i_q]);
					if (sum_i_q == IW'(N - 1)) begin
						st_q <= ST_OUT;
					end else begin
						sum_i_q <= sum_i_q + IW'(1);
					end
				end
				ST_OUT: begin
					if (!out_v_q || out_ready) begin
						out_cum_q <= point_q;
						out_tot_q <= point_q + total_q;
						out_cnt_q <= 5'(held_q);
						out_ovf_q <= ovf_q;
						out_v_q   <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_v_q && out_ready && st_q != ST_OUT) out_v_q <= 1'b0;
		end
	end

	assign out_valid      = out_v_q;
	assign cum_point      = out_cum_q;
	assign total_received = out_tot_q;
	assign block_count    = out_cnt_q;
	assign overflow       = out_ovf_q;
endmodule

>>> hw/rtl/sack_checker.sv
// sack_checker: port-level assertions for sack_reassembly_scoreboard.
// Depends on the top level's ports only; bound below.
module sack_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] cum_point,
	input logic [31:0] total_received,
	input logic [4:0]  block_count,
	input logic        overflow
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cum_point))
		else $error("result changed while stalled");
	a_tot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_received >= cum_point)
		else $error("total below point");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after accept");
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && $changed(cum_point) |->
		cum_point > $past(cum_point))
		else $error("point went back");
endmodule

bind sack_reassembly_scoreboard sack_checker u_chk (.*);

>>> bench/sack_reassembly_scoreboard_tb.sv
// Testbench for sack_reassembly_scoreboard: random and directed byte ranges are
// checked against an in-bench scoreboard predictor. Depends on sack_pkg and the block.
`timescale 1ns / 1ps
module sack_reassembly_scoreboard_tb;
	localparam int unsigned NBLK = sack_pkg::MAX_BLOCKS_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [31:0] s;
		logic [15:0] len;
	} range_t;

	typedef struct {
		logic [31:0] cum;
		logic [31:0] total;
		logic [4:0]  cnt;
		logic        ovf;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] seq_start = '0;
	logic [15:0] range_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] cum_point;
	logic [31:0] total_received;
	logic [4:0]  block_count;
	logic        overflow;

	range_t  pending_ranges[$];
	status_t expected_status[$];
	int      mismatches = 0;
	int      cycles = 0;
	int      hold_left = 0;
	bit      hold_req = 0;
	bit      hold_seen = 0;
	bit      in_taken = 0;
	bit      quiet = 0;

	logic [31:0] pt = '0;
	logic [31:0] bb[NBLK];
	logic [31:0] bl[NBLK];
	int          nheld = 0;

	sack_reassembly_scoreboard dut (.*);

	always #10 clk = ~clk;

	function automatic status_t predict_status(range_t r);
		status_t st;
		logic [32:0] e33;
		logic [31:0] s, e, b, be;
		logic [63:0] tot;
		logic [31:0] nb[NBLK];
		logic [31:0] nl[NBLK];
		int i, k, n, touched;
		bit placed;
		s = r.s;
		e33 = {1'b0, r.s} + 33'(r.len);
		e = e33[32] ? 32'hFFFF_FFFF : e33[31:0];
		st.ovf = 1'b0;
		if (r.len != 0 && e > s && e > pt) begin
			if (s <= pt) begin
				pt = e;
				i = 0;
				while (i < nheld && bb[i] <= pt) begin
					if (bb[i] + bl[i] > pt) pt = bb[i] + bl[i];
					i++;
				end
				for (k = 0; k + i < nheld; k++) begin
					bb[k] = bb[k + i];
					bl[k] = bl[k + i];
				end
				nheld -= i;
			end else begin
				touched = 0;
				for (i = 0; i < nheld; i++)
					if (bb[i] <= e && bb[i] + bl[i] >= s) touched++;
				if (touched == 0 && nheld >= NBLK) begin
					st.ovf = 1'b1;
				end else begin
					n = 0;
					placed = 0;
					for (i = 0; i < nheld; i++) begin
						b = bb[i];
						be = bb[i] + bl[i];
						if (be < s) begin
							nb[n] = b; nl[n] = bl[i]; n++;
						end else if (b > e) begin
							if (!placed) begin
								nb[n] = s; nl[n] = e - s; n++; placed = 1;
							end
							nb[n] = b; nl[n] = bl[i]; n++;
						end else begin
							if (b < s) s = b;
							if (be > e) e = be;
						end
					end
					if (!placed) begin
						nb[n] = s; nl[n] = e - s; n++;
					end
					for (i = 0; i < n; i++) begin
						bb[i] = nb[i];
						bl[i] = nl[i];
					end
					nheld = n;
				end
			end
		end
		tot = 64'(pt);
		for (i = 0; i < nheld; i++) tot += 64'(bl[i]);
		st.cum = pt;
		st.total = tot[31:0];
		st.cnt = nheld[4:0];
		return st;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	task automatic push_range(logic [31:0] s, logic [15:0] len);
		range_t r;
		r.s = s;
		r.len = len;
		pending_ranges.push_back(r);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_ranges.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
					seq_start <= pending_ranges[0].s;
					range_length <= pending_ranges[0].len;
					in_valid <= 1'b1;
					expected_status.push_back(predict_status(pending_ranges.pop_front()));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_seen) begin
				hold_seen <= 1'b1;
				hold_left <= 300;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 10;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_taken <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected word", cum_point, '0);
			end else begin
				status_t w;
				w = expected_status.pop_front();
				if (cum_point !== w.cum) report_mismatch("cum_point", cum_point, w.cum);
				if (total_received !== w.total)
					report_mismatch("total_received", total_received, w.total);
				if (block_count !== w.cnt)
					report_mismatch("block_count", 32'(block_count), 32'(w.cnt));
				if (overflow !== w.ovf)
					report_mismatch("overflow", 32'(overflow), 32'(w.ovf));
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] base;
		int i, kind;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty, at point, gaps, top clipping, overflow, merges
		push_range(32'd0, 16'd0);
		push_range(32'd0, 16'd100);
		push_range(32'd50, 16'd10);
		for (i = 0; i < 17; i++) push_range(32'd200 + i * 20, 16'd5);
		push_range(32'd205, 16'd15);
		push_range(32'd100, 16'd100);
		push_range(32'hFFFF_FFF0, 16'hFFFF);
		push_range(32'hFFFF_FFFF, 16'd1);
		push_range(32'd0, 16'hFFFF);
		wait (pending_ranges.size() == 0 && expected_status.size() == 0);
		repeat (40) @(posedge clk);
		// second epoch restarts through reset-free path: keep point growing
		hold_req = 1;
		for (i = 0; i < 1800; i++) begin
			if (i == 600) quiet = 1;
			if (i == 900) quiet = 0;
			kind = $urandom_range(9);
			base = pt;
			if (i % 200 == 0 && i > 0) begin
				push_range($urandom, 16'($urandom));
			end else if (kind < 6) begin
				push_range(base + $urandom_range(2000), 16'($urandom_range(1, 300)));
			end else if (kind < 8) begin
				push_range(base - $urandom_range(50), 16'($urandom_range(1, 400)));
			end else if (kind == 8) begin
				push_range(base > 500 ? base - 500 : 32'd0, 16'($urandom_range(0, 400)));
			end else begin
				push_range($urandom, 16'($urandom));
			end
			// let the predictor state track before basing on pt
			wait (pending_ranges.size() < 4);
		end
		wait (pending_ranges.size() == 0 && expected_status.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
